/* hdl/ppue_pkg.sv */
`timescale 1ns / 1ps
package ppue_pkg;
  localparam int QW = 24;
  localparam logic [15:0] LIFE_FULL = 16'd256;
  localparam logic [0:0] OP_CREATE = 1'b0;
  localparam logic [0:0] OP_TICK = 1'b1;
  localparam logic [0:0] KIND_CREATE = 1'b0;
  localparam logic [0:0] KIND_UPDATE = 1'b1;
  localparam logic [1:0] REG_LIFE_RATE = 2'd0;
  localparam logic [1:0] REG_GRAV_X = 2'd1;
  localparam logic [1:0] REG_GRAV_Y = 2'd2;
  localparam logic [1:0] REG_GRAV_Z = 2'd3;

  // one particle's stored state, minus life
  typedef struct packed {
    logic signed [QW-1:0] px;
    logic signed [QW-1:0] py;
    logic signed [QW-1:0] pz;
    logic signed [QW-1:0] vx;
    logic signed [QW-1:0] vy;
    logic signed [QW-1:0] vz;
    logic [23:0] color;
  } part_t;

  // (a * dt) >> 16, floor
  function automatic logic signed [QW-1:0] scale_dt(input logic signed [QW-1:0] a,
                                                    input logic [15:0] dt);
    logic signed [40:0] p;
    p = a * $signed({1'b0, dt});
    return p[39:16];
  endfunction

  function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    return s[QW-1:0];
  endfunction
endpackage

/* hdl/particle_pool_update_engine_core.sv */
`timescale 1ns / 1ps
// Particle pool with create and tick beats. A create beat reads life memory one slot
// at a time from the last used slot, wrapping, for a dead particle (a read and a check
// per slot; if every slot is live it falls back to slot zero) and emits one result
// beat. A tick beat walks every slot once, one read-modify-write per slot through the
// life and state memories; each live slot yields one result beat and the final one
// carries last_of_run. One result is held back in a register until the next live
// slot or the end of the walk shows whether it is the last. A result beat that waits
// for out_ready stalls the engine, and a new beat is accepted only back in idle. The
// memories hold no reset: each slot has a live bit cleared by reset and an entry
// counts only once a create has set it. Configuration writes are to be made only
// while idle; the block itself does not enforce this.
module particle_pool_update_engine_core import ppue_pkg::*; #(
  parameter int PARTICLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  operation,
  input  logic signed [23:0] pos_x, pos_y, pos_z,
  input  logic [7:0]  color_r, color_g, color_b,
  input  logic signed [23:0] vel_x, vel_y, vel_z,
  input  logic [15:0] time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [0:0]  kind,
  output logic [5:0]  slot,
  output logic signed [23:0] out_pos_x,
  output logic [22:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic [7:0]  out_color_r, out_color_g, out_color_b,
  output logic        last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int SW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  typedef enum logic [2:0] {IDLE, SRD, SCHK, CREATE, TRD, TWR, OUTW} st_t;
  st_t st;

  logic [15:0] life_rate;
  logic signed [23:0] grav_x, grav_y, grav_z;
  logic [15:0] life_mem [PARTICLES];
  logic [15:0] life_rd;
  logic [PARTICLES-1:0] live_v;   // slot written by a create since reset
  part_t mem [PARTICLES];
  part_t rd;
  logic [SW-1:0] last_used, idx;
  logic [6:0] steps;
  logic [15:0] dt;
  part_t newp;
  logic [15:0] dec, life_cur;
  logic pend;                 // a live slot result is held back to learn last_of_run
  part_t hold;
  logic [SW-1:0] hold_slot;
  part_t upd;
  logic [31:0] dprod;
  logic out_free;
  logic out_valid_next;

  assign in_ready = (st == IDLE);
  assign dprod = dt * life_rate;
  assign dec = dprod[31:16];
  assign out_free = !out_valid || out_ready;

  // update of the slot whose state memory read just landed
  always_comb begin
    upd = rd;
    upd.px = sat_add(rd.px, scale_dt(rd.vx, dt));
    upd.py = sat_add(rd.py, scale_dt(rd.vy, dt));
    upd.pz = sat_add(rd.pz, scale_dt(rd.vz, dt));
    upd.vx = sat_add(rd.vx, scale_dt(grav_x, dt));
    upd.vy = sat_add(rd.vy, scale_dt(grav_y, dt));
    upd.vz = sat_add(rd.vz, scale_dt(grav_z, dt));
    if (upd.py < 0) upd.py = '0;
  end

  // life of the slot whose life memory read just landed, dead until created
  assign life_cur = live_v[idx] ? life_rd : '0;

  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (st == CREATE && out_free) out_valid_next = 1'b1;
    if (st == TWR && out_free && life_cur != 0 && pend) out_valid_next = 1'b1;
    if (st == OUTW && out_free && pend) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (st == TRD) rd <= mem[idx];
    if (st == TRD || st == SRD) life_rd <= life_mem[idx];
    if (st == CREATE) mem[idx] <= newp;
    else if (st == TWR && life_cur != 0) mem[idx] <= upd;
    if (st == CREATE && out_free) life_mem[idx] <= LIFE_FULL;
    else if (st == TWR && out_free && life_cur != 0)
      life_mem[idx] <= (life_cur > dec) ? life_cur - dec : '0;
  end

  task automatic load_out(input part_t p, input logic [0:0] k, input logic [SW-1:0] s);
    kind <= k;
    slot <= 6'(s);
    out_pos_x <= p.px;
    out_pos_y <= p.py[23] ? 23'd0 : p.py[22:0];
    out_pos_z <= p.pz;
    out_color_r <= p.color[23:16];
    out_color_g <= p.color[15:8];
    out_color_b <= p.color[7:0];
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
      out_valid <= 1'b0;
      pend <= 1'b0;
      last_used <= '0;
      live_v <= '0;
      life_rate <= 16'd256;
      grav_x <= '0;
      grav_y <= -24'sd40181;
      grav_z <= '0;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LIFE_RATE: life_rate <= cfg_data[15:0];
          REG_GRAV_X: grav_x <= cfg_data;
          REG_GRAV_Y: grav_y <= cfg_data;
          REG_GRAV_Z: grav_z <= cfg_data;
          default: ;
        endcase
      end
      case (st)
        IDLE: if (in_valid) begin
          dt <= time_step;
          newp <= '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, {color_r, color_g, color_b}};
          steps <= '0;
          pend <= 1'b0;
          if (operation == OP_CREATE) begin
            idx <= last_used;
            st <= SRD;
          end else begin
            idx <= '0;
            st <= TRD;
          end
        end
        SRD: st <= SCHK;
        SCHK: begin
          if (life_cur == 0) st <= CREATE;
          else if (steps == 7'(PARTICLES - 1)) begin
            // every slot is live, fall back to slot zero
            idx <= '0;
            st <= CREATE;
          end else begin
            steps <= steps + 7'd1;
            idx <= (idx == SW'(PARTICLES - 1)) ? '0 : idx + 1'b1;
            st <= SRD;
          end
        end
        CREATE: if (out_free) begin
          live_v[idx] <= 1'b1;
          last_used <= idx;
          load_out(newp, KIND_CREATE, idx);
          last_of_run <= 1'b1;
          st <= IDLE;
        end
        TRD: st <= TWR;
        TWR: if (out_free) begin
          if (life_cur != 0) begin
            // the previous held result goes out now, not last
            if (pend) begin
              load_out(hold, KIND_UPDATE, hold_slot);
              last_of_run <= 1'b0;
            end
            hold <= upd;
            hold_slot <= idx;
            pend <= 1'b1;
          end
          if (idx == SW'(PARTICLES - 1)) st <= OUTW;
          else begin
            idx <= idx + 1'b1;
            st <= TRD;
          end
        end
        OUTW: if (out_free) begin
          if (pend) begin
            load_out(hold, KIND_UPDATE, hold_slot);
            last_of_run <= 1'b1;
          end
          pend <= 1'b0;
          st <= IDLE;
        end
        default: st <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (st != IDLE) |-> !in_ready) else $error("accept while busy");
  a_create_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_CREATE) |-> last_of_run) else $error("create without last");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(slot)) else $error("beat dropped");
`endif
endmodule

/* tb/particle_pool_update_engine_core_tb.sv */
`timescale 1ns / 1ps
module particle_pool_update_engine_core_tb import ppue_pkg::*;;

  localparam int NSLOT = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_ITEMS = 410;

  typedef struct packed {
    logic [0:0] op;
    logic signed [23:0] px, py, pz;
    logic [7:0] r, g, b;
    logic signed [23:0] vx, vy, vz;
    logic [15:0] dt;
  } pool_cmd_t;

  typedef struct packed {
    logic [0:0] kind;
    logic [5:0] slot;
    logic signed [23:0] px;
    logic [22:0] py;
    logic signed [23:0] pz;
    logic [7:0] r, g, b;
    logic last;
  } particle_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] operation = OP_CREATE;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [7:0] color_r = '0, color_g = '0, color_b = '0;
  logic signed [23:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [15:0] time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [0:0] kind;
  logic [5:0] slot;
  logic signed [23:0] out_pos_x, out_pos_z;
  logic [22:0] out_pos_y;
  logic [7:0] out_color_r, out_color_g, out_color_b;
  logic last_of_run;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_LIFE_RATE;
  logic [23:0] cfg_data = '0;

  particle_pool_update_engine_core i_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow of the pool, kept in step with accepted beats
  logic [15:0] sh_life [NSLOT];
  logic signed [23:0] sh_px [NSLOT], sh_py [NSLOT], sh_pz [NSLOT];
  logic signed [23:0] sh_vx [NSLOT], sh_vy [NSLOT], sh_vz [NSLOT];
  logic [23:0] sh_color [NSLOT];
  logic [5:0] sh_last_slot;
  logic [15:0] sh_life_rate;
  logic signed [23:0] sh_grav_x, sh_grav_y, sh_grav_z;

  pool_cmd_t pending_cmds[$];
  particle_report_t expected_reports[$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic void add_report(input particle_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic void add_cmd(input pool_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // floor of (a * dt) / 2^16
  function automatic logic signed [23:0] dt_scaled(logic signed [23:0] a, logic [15:0] dt);
    longint p;
    p = longint'(a) * longint'(dt);
    return 24'(p >>> 16);
  endfunction

  function automatic logic signed [23:0] clip24(logic signed [23:0] a, logic signed [23:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 8388607) return 24'sd8388607;
    if (s < -8388608) return -24'sd8388608;
    return 24'(s);
  endfunction

  function automatic particle_report_t report_of(logic [0:0] k, int s);
    particle_report_t rep;
    rep.kind = k;
    rep.slot = 6'(s);
    rep.px = sh_px[s];
    rep.py = sh_py[s][23] ? 23'd0 : sh_py[s][22:0];
    rep.pz = sh_pz[s];
    {rep.r, rep.g, rep.b} = sh_color[s];
    rep.last = 1'b0;
    return rep;
  endfunction

  task automatic predict_pool(input pool_cmd_t c);
    int s;
    int found;
    int n;
    logic [15:0] dec;
    if (c.op == OP_CREATE) begin
      found = -1;
      for (int i = sh_last_slot; i < NSLOT; i++)
        if (found < 0 && sh_life[i] == 0) found = i;
      for (int i = 0; i < sh_last_slot; i++)
        if (found < 0 && sh_life[i] == 0) found = i;
      s = (found < 0) ? 0 : found;
      sh_last_slot = 6'(s);
      sh_px[s] = c.px; sh_py[s] = c.py; sh_pz[s] = c.pz;
      sh_vx[s] = c.vx; sh_vy[s] = c.vy; sh_vz[s] = c.vz;
      sh_color[s] = {c.r, c.g, c.b};
      sh_life[s] = LIFE_FULL;
      add_report(report_of(KIND_CREATE, s));
      expected_reports[$].last = 1'b1;
    end else begin
      n = 0;
      dec = 16'((32'(c.dt) * 32'(sh_life_rate)) >> 16);
      for (int i = 0; i < NSLOT; i++) begin
        if (sh_life[i] != 0) begin
          sh_life[i] = (sh_life[i] > dec) ? sh_life[i] - dec : 16'd0;
          // position moves by the old velocity
          sh_px[i] = clip24(sh_px[i], dt_scaled(sh_vx[i], c.dt));
          sh_py[i] = clip24(sh_py[i], dt_scaled(sh_vy[i], c.dt));
          sh_pz[i] = clip24(sh_pz[i], dt_scaled(sh_vz[i], c.dt));
          sh_vx[i] = clip24(sh_vx[i], dt_scaled(sh_grav_x, c.dt));
          sh_vy[i] = clip24(sh_vy[i], dt_scaled(sh_grav_y, c.dt));
          sh_vz[i] = clip24(sh_vz[i], dt_scaled(sh_grav_z, c.dt));
          if (sh_py[i] < 0) sh_py[i] = '0;
          add_report(report_of(KIND_UPDATE, i));
          n++;
        end
      end
      if (n > 0) expected_reports[$].last = 1'b1;
    end
  endtask

  function automatic pool_cmd_t rand_cmd(logic [0:0] op, bit wide);
    pool_cmd_t c;
    c.op = op;
    c.px = 24'($urandom); c.py = 24'($urandom); c.pz = 24'($urandom);
    c.r = 8'($urandom); c.g = 8'($urandom); c.b = 8'($urandom);
    c.vx = 24'($urandom); c.vy = 24'($urandom); c.vz = 24'($urandom);
    c.dt = 16'($urandom);
    // mostly modest values so particles survive several ticks
    if (!wide) begin
      c.px = 24'($signed($urandom_range(0, 400000)) - 200000);
      c.py = 24'($urandom_range(0, 400000));
      c.vy = 24'($signed($urandom_range(0, 100000)) - 20000);
      c.dt = 16'($urandom_range(0, 3000));
    end
    return c;
  endfunction

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_pool({operation, pos_x, pos_y, pos_z, color_r, color_g, color_b,
                      vel_x, vel_y, vel_z, time_step});
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          {operation, pos_x, pos_y, pos_z, color_r, color_g, color_b,
           vel_x, vel_y, vel_z, time_step} <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and result check
  logic [7:0] stall_pattern = 8'hff;
  int stall_phase = 0;
  particle_report_t want, got;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{kind, slot, out_pos_x, out_pos_y, out_pos_z,
                out_color_r, out_color_g, out_color_b, last_of_run};
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 63) stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      out_ready <= stall_pattern[stall_phase % 8];
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LIFE_RATE: sh_life_rate = val[15:0];
      REG_GRAV_X: sh_grav_x = val;
      REG_GRAV_Y: sh_grav_y = val;
      default: sh_grav_z = val;
    endcase
  endtask

  task automatic drain_pool();
    while (pending_cmds.size() > 0 || in_valid || expected_reports.size() > 0) @(posedge clk);
    // a tick with nothing alive may still be walking the slots
    repeat (4 * NSLOT + 20) @(posedge clk);
  endtask

  task automatic run_random(input int count, input logic [15:0] lr);
    pool_cmd_t c;
    write_reg(REG_LIFE_RATE, {8'd0, lr});
    write_reg(REG_GRAV_X, 24'($urandom));
    write_reg(REG_GRAV_Y, 24'($signed($urandom_range(0, 80000)) - 60000));
    write_reg(REG_GRAV_Z, 24'($urandom_range(0, 2000)));
    for (int i = 0; i < count; i++) begin
      c = rand_cmd(($urandom_range(0, 9) < 6) ? OP_CREATE : OP_TICK,
                   $urandom_range(0, 7) == 0);
      add_cmd(c);
    end
    drain_pool();
  endtask

  initial begin
    pool_cmd_t c;
    for (int i = 0; i < NSLOT; i++) sh_life[i] = '0;
    sh_last_slot = '0;
    sh_life_rate = 16'd256;
    sh_grav_x = '0; sh_grav_y = -24'sd40181; sh_grav_z = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: tick with nothing alive, then extremes
    c = rand_cmd(OP_TICK, 1'b0); c.dt = 16'hffff; add_cmd(c);
    c = rand_cmd(OP_CREATE, 1'b1);
    c.px = 24'h7fffff; c.py = 24'h800000; c.pz = 24'h800000;
    c.vx = 24'h7fffff; c.vy = 24'h800000; c.vz = 24'h800000;
    c.r = 8'hff; c.g = 8'h00; c.b = 8'hff;
    add_cmd(c);
    c.px = 24'h800000; c.py = 24'h7fffff; c.pz = 24'h7fffff;
    c.vx = 24'h800000; c.vy = 24'h7fffff; c.vz = 24'h7fffff;
    c.r = 8'h00; c.g = 8'hff; c.b = 8'h00;
    add_cmd(c);
    c = rand_cmd(OP_TICK, 1'b0); c.dt = 16'hffff; add_cmd(c);
    c.dt = 16'h0000; add_cmd(c);
    c.dt = 16'h8000; add_cmd(c);
    drain_pool();
    // ageing off and extreme gravity, sixteen creates, then a tick
    write_reg(REG_LIFE_RATE, 24'd0);
    write_reg(REG_GRAV_X, 24'h7fffff);
    write_reg(REG_GRAV_Y, 24'h800000);
    write_reg(REG_GRAV_Z, 24'h800000);
    for (int i = 0; i < 16; i++) add_cmd(rand_cmd(OP_CREATE, 1'b0));
    c = rand_cmd(OP_TICK, 1'b0); c.dt = 16'hffff; add_cmd(c);
    drain_pool();
    run_random(140, 16'd0);
    write_reg(REG_GRAV_X, 24'h800000);
    write_reg(REG_GRAV_Y, 24'h7fffff);
    write_reg(REG_GRAV_Z, 24'h7fffff);
    c = rand_cmd(OP_TICK, 1'b0); c.dt = 16'hffff; add_cmd(c);
    drain_pool();
    // full-rate ageing kills everything, then random rates
    write_reg(REG_LIFE_RATE, 24'hffff);
    c = rand_cmd(OP_TICK, 1'b0); c.dt = 16'hffff; add_cmd(c);
    drain_pool();
    run_random(RAND_ITEMS - 140 - 130, 16'($urandom));
    run_random(130, 16'($urandom_range(0, 3000)));
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
